FILE: rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and reset values of the one-wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  localparam int unsigned TimerBits   = 10;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitCntBits  = $clog2(BitsPerByte);
  localparam int unsigned CfgIdxBits  = 3;

  typedef logic [TimerBits-1:0]   timer_t;
  typedef logic [BitsPerByte-1:0] byte_t;
  typedef logic [BitCntBits-1:0]  bit_cnt_t;

  localparam timer_t ResetLowDefault     = timer_t'(480);
  localparam timer_t PresenceWaitDefault = timer_t'(30);
  localparam timer_t PresenceHoldDefault = timer_t'(60);
  localparam timer_t ZeroLowDefault      = timer_t'(10);
  localparam timer_t ShortLowDefault     = timer_t'(1);
  localparam timer_t RecoveryDefault     = timer_t'(10);

  localparam bit_cnt_t LastBit = bit_cnt_t'(BitsPerByte - 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_HOLD = 3'd3,
    PH_WR_LOW   = 3'd4,
    PH_WR_REC   = 3'd5,
    PH_RD_LOW   = 3'd6,
    PH_RD_REC   = 3'd7
  } phase_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_PRESENCE_HOLD = 3'd2,
    CFG_ZERO_LOW      = 3'd3,
    CFG_SHORT_LOW     = 3'd4,
    CFG_RECOVERY      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    timer_t reset_low_us;
    timer_t presence_wait_us;
    timer_t presence_hold_us;
    timer_t zero_low_us;
    timer_t short_low_us;
    timer_t recovery_us;
  } cfg_t;

  typedef struct packed {
    op_e   op;
    byte_t write_data;
    logic  line_in;
  } req_t;

  typedef struct packed {
    logic  line_release;
    logic  busy_res;
    logic  done_res;
    logic  presence;
    byte_t read_data;
    logic  rejected;
  } res_t;

  function automatic timer_t at_least_one(timer_t v);
    return (v == '0) ? timer_t'(1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/owbm_req_if.sv
// ----------------------------------------------------------------------------
// owbm_req_if
// Request channel: command, write byte and sampled line level.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_req_if;
  logic                 valid;
  logic                 ready;
  owbm_pkg::op_e        op;
  owbm_pkg::byte_t      write_data;
  logic                 line_in;

  modport source (output valid, output op, output write_data, output line_in, input ready);
  modport sink   (input valid, input op, input write_data, input line_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/owbm_res_if.sv
// ----------------------------------------------------------------------------
// owbm_res_if
// Result channel: line drive, status flags and read byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_res_if;
  logic            valid;
  logic            ready;
  logic            line_release;
  logic            busy_res;
  logic            done_res;
  logic            presence;
  owbm_pkg::byte_t read_data;
  logic            rejected;

  modport source (output valid, output line_release, output busy_res, output done_res,
                  output presence, output read_data, output rejected, input ready);
  modport sink   (input valid, input line_release, input busy_res, input done_res,
                  input presence, input read_data, input rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/owbm_cfg_if.sv
// ----------------------------------------------------------------------------
// owbm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [owbm_pkg::CfgIdxBits-1:0]       idx;
  owbm_pkg::timer_t                      wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Timing registers of the bus master, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [owbm_pkg::CfgIdxBits-1:0] idx_i,
  input  wire owbm_pkg::timer_t                wdata_i,
  output owbm_pkg::cfg_t                       cfg_o
);

  owbm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (owbm_pkg::cfg_idx_e'(idx_i))
        owbm_pkg::CFG_RESET_LOW:     cfg_d.reset_low_us     = wdata_i;
        owbm_pkg::CFG_PRESENCE_WAIT: cfg_d.presence_wait_us = wdata_i;
        owbm_pkg::CFG_PRESENCE_HOLD: cfg_d.presence_hold_us = wdata_i;
        owbm_pkg::CFG_ZERO_LOW:      cfg_d.zero_low_us      = wdata_i;
        owbm_pkg::CFG_SHORT_LOW:     cfg_d.short_low_us     = wdata_i;
        owbm_pkg::CFG_RECOVERY:      cfg_d.recovery_us      = wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us     <= owbm_pkg::ResetLowDefault;
      cfg_q.presence_wait_us <= owbm_pkg::PresenceWaitDefault;
      cfg_q.presence_hold_us <= owbm_pkg::PresenceHoldDefault;
      cfg_q.zero_low_us      <= owbm_pkg::ZeroLowDefault;
      cfg_q.short_low_us     <= owbm_pkg::ShortLowDefault;
      cfg_q.recovery_us      <= owbm_pkg::RecoveryDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/owbm_step.sv
// ----------------------------------------------------------------------------
// owbm_step
// Bus state and the single-tick step: phase, slot timer, bit counter, shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire owbm_pkg::req_t req_i,
  input  wire owbm_pkg::cfg_t cfg_i,
  output owbm_pkg::res_t      res_o
);

  owbm_pkg::phase_e   phase_q, phase_d;
  owbm_pkg::op_e      cmd_q, cmd_d;
  owbm_pkg::timer_t   tick_q, tick_d;
  owbm_pkg::bit_cnt_t bits_q, bits_d;
  owbm_pkg::byte_t    shift_q, shift_d;
  owbm_pkg::byte_t    rd_q, rd_d;
  logic               pres_q, pres_d;

  owbm_pkg::timer_t   slot_len;
  logic               slot_end;
  logic               line_release;
  logic               done;
  logic               rejected;

  always_comb begin
    phase_d      = phase_q;
    cmd_d        = cmd_q;
    tick_d       = tick_q;
    bits_d       = bits_q;
    shift_d      = shift_q;
    rd_d         = rd_q;
    pres_d       = pres_q;
    line_release = 1'b1;
    done         = 1'b0;
    rejected     = 1'b0;
    slot_len     = owbm_pkg::at_least_one(cfg_i.recovery_us);
    slot_end     = 1'b0;

    if (phase_q == owbm_pkg::PH_IDLE) begin
      if (req_i.op != owbm_pkg::OP_TICK) begin
        cmd_d  = req_i.op;
        tick_d = '0;
        bits_d = '0;
        case (req_i.op)
          owbm_pkg::OP_RESET: begin
            phase_d = owbm_pkg::PH_RST_LOW;
            pres_d  = 1'b0;
          end
          owbm_pkg::OP_WRITE: begin
            shift_d = req_i.write_data;
            phase_d = owbm_pkg::PH_WR_LOW;
          end
          default: begin
            shift_d = '0;
            phase_d = owbm_pkg::PH_RD_LOW;
          end
        endcase
      end
    end else if (req_i.op != owbm_pkg::OP_TICK) begin
      rejected = 1'b1;
    end

    if (phase_d != owbm_pkg::PH_IDLE) begin
      line_release = !(phase_d == owbm_pkg::PH_RST_LOW || phase_d == owbm_pkg::PH_WR_LOW ||
                       phase_d == owbm_pkg::PH_RD_LOW);
      tick_d = tick_d + owbm_pkg::timer_t'(1);
      if (phase_d == owbm_pkg::PH_RD_REC && tick_d == owbm_pkg::timer_t'(1)) begin
        shift_d = {req_i.line_in, shift_d[owbm_pkg::BitsPerByte-1:1]};
      end
      case (phase_d)
        owbm_pkg::PH_RST_LOW:  slot_len = owbm_pkg::at_least_one(cfg_i.reset_low_us);
        owbm_pkg::PH_RST_WAIT: slot_len = owbm_pkg::at_least_one(cfg_i.presence_wait_us);
        owbm_pkg::PH_RST_HOLD: slot_len = owbm_pkg::at_least_one(cfg_i.presence_hold_us);
        owbm_pkg::PH_WR_LOW:   slot_len = shift_d[0] ?
                                          owbm_pkg::at_least_one(cfg_i.short_low_us) :
                                          owbm_pkg::at_least_one(cfg_i.zero_low_us);
        owbm_pkg::PH_RD_LOW:   slot_len = owbm_pkg::at_least_one(cfg_i.short_low_us);
        default:               slot_len = owbm_pkg::at_least_one(cfg_i.recovery_us);
      endcase
      if (tick_d >= slot_len) begin
        tick_d = '0;
        case (phase_d)
          owbm_pkg::PH_RST_LOW: phase_d = owbm_pkg::PH_RST_WAIT;
          owbm_pkg::PH_RST_WAIT: begin
            pres_d = !req_i.line_in;
            if (pres_d && cfg_i.presence_hold_us != '0) begin
              phase_d = owbm_pkg::PH_RST_HOLD;
            end else begin
              phase_d = owbm_pkg::PH_IDLE;
              done    = 1'b1;
            end
          end
          owbm_pkg::PH_RST_HOLD: begin
            phase_d = owbm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          owbm_pkg::PH_WR_LOW: begin
            if (cfg_i.recovery_us != '0) phase_d = owbm_pkg::PH_WR_REC;
            else slot_end = 1'b1;
          end
          owbm_pkg::PH_RD_LOW: phase_d = owbm_pkg::PH_RD_REC;
          default:             slot_end = 1'b1;
        endcase
      end
    end

    if (slot_end) begin
      if (cmd_d == owbm_pkg::OP_WRITE) shift_d = shift_d >> 1;
      if (bits_d == owbm_pkg::LastBit) begin
        if (cmd_d == owbm_pkg::OP_READ) rd_d = shift_d;
        phase_d = owbm_pkg::PH_IDLE;
        done    = 1'b1;
      end else begin
        bits_d  = bits_d + owbm_pkg::bit_cnt_t'(1);
        phase_d = (cmd_d == owbm_pkg::OP_WRITE) ? owbm_pkg::PH_WR_LOW : owbm_pkg::PH_RD_LOW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      cmd_q   <= owbm_pkg::OP_TICK;
      tick_q  <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      rd_q    <= '0;
      pres_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      rd_q    <= rd_d;
      pres_q  <= pres_d;
    end
  end

  assign res_o.line_release = line_release;
  assign res_o.busy_res     = (phase_d != owbm_pkg::PH_IDLE);
  assign res_o.done_res     = done;
  assign res_o.presence     = pres_d;
  assign res_o.read_data    = rd_d;
  assign res_o.rejected     = rejected;

`ifndef SYNTH
  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.done_res |-> !res_o.busy_res)
    else $error("command completed but still busy");

  a_reject_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.rejected |-> phase_q != owbm_pkg::PH_IDLE)
    else $error("request rejected while idle");

  a_idle_timer_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == owbm_pkg::PH_IDLE |-> tick_q == '0)
    else $error("slot timer running while idle");

  a_done_lands_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.done_res |=> phase_q == owbm_pkg::PH_IDLE)
    else $error("phase not idle after completion");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/one_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// One-wire bus master stepped by one microsecond tick per request.
// ----------------------------------------------------------------------------
// Every request is one bus tick and yields exactly one result. A request is
// taken into an input register, stepped through the bus state in a single
// pass and lands in a result register, so one request per clock is
// sustained unless results stall; a stalled result register holds the
// input register, which takes a new request while the result is drained.
// Timing registers are written through the configuration channel, which is
// always ready, and should be written only while no command is running.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  owbm_req_if.sink    req_i,
  owbm_res_if.source  res_o,
  owbm_cfg_if.sink    cfg_i
);

  logic             in_valid_q, in_valid_d;
  owbm_pkg::req_t   in_req_q;
  logic             out_valid_q, out_valid_d;
  owbm_pkg::res_t   out_res_q;
  owbm_pkg::res_t   step_res;
  owbm_pkg::cfg_t   cfg;
  logic             adv;
  logic             take;

  assign adv   = in_valid_q && (!out_valid_q || res_o.ready);
  assign take  = req_i.valid && req_i.ready;
  assign req_i.ready = !in_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  assign in_valid_d  = take ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  owbm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_i.valid),
    .idx_i   (cfg_i.idx),
    .wdata_i (cfg_i.wdata),
    .cfg_o   (cfg)
  );

  owbm_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_req_q.op         <= req_i.op;
      in_req_q.write_data <= req_i.write_data;
      in_req_q.line_in    <= req_i.line_in;
    end
    if (adv) out_res_q <= step_res;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.line_release = out_res_q.line_release;
  assign res_o.busy_res     = out_res_q.busy_res;
  assign res_o.done_res     = out_res_q.done_res;
  assign res_o.presence     = out_res_q.presence;
  assign res_o.read_data    = out_res_q.read_data;
  assign res_o.rejected     = out_res_q.rejected;

`ifndef SYNTH
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |-> !req_i.ready)
    else $error("input register overwritten while held");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("stepped request produced no result");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |-> !adv)
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
